// ----- rtl/qlmi_pkg.sv -----
//------------------------------------------------------------------------------
// qlmi_pkg
// shared types, codes and constants of the linear move interpolator
//------------------------------------------------------------------------------
package qlmi_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int COORD_W         = 24;
    localparam int STEP_W          = 16;

    // input kinds
    localparam logic [1:0] KIND_TARGET = 2'd0;
    localparam logic [1:0] KIND_MOVE   = 2'd1;
    localparam logic [1:0] KIND_JOG    = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_REACHED = 2'd2;

    // register indexes
    localparam logic [2:0] REG_MIN_X     = 3'd0;
    localparam logic [2:0] REG_MAX_X     = 3'd1;
    localparam logic [2:0] REG_MIN_Y     = 3'd2;
    localparam logic [2:0] REG_MAX_Y     = 3'd3;
    localparam logic [2:0] REG_MIN_Z     = 3'd4;
    localparam logic [2:0] REG_MAX_Z     = 3'd5;
    localparam logic [2:0] REG_MOVE_STEP = 3'd6;
    localparam logic [2:0] REG_JOG_STEP  = 3'd7;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [23:0] target_x;
        logic signed [23:0] target_y;
        logic signed [23:0] target_z;
        logic [2:0]         axis_mask;
        logic [5:0]         jog_keys;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic [4:0]         pending;
        logic [1:0]         status;
    } out_item_t;

    // request / answer of the shared sqrt and divide unit
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [49:0] num;
        logic [25:0] den;
    } alu_req_t;

    typedef struct packed {
        logic        done;
        logic [49:0] quo;
    } alu_rsp_t;

endpackage

// ----- rtl/qlmi_alu.sv -----
//------------------------------------------------------------------------------
// qlmi_alu
// shared bit-serial unit: integer square root or unsigned division
//------------------------------------------------------------------------------
module qlmi_alu
(
    input  logic                clk,
    input  logic                rst_n,
    input  qlmi_pkg::alu_req_t  req,
    output qlmi_pkg::alu_rsp_t  rsp
);

    logic        busy_reg;
    logic        is_div_reg;
    logic [5:0]  cnt_reg;
    logic [49:0] num_reg;
    logic [50:0] rem_reg;
    logic [49:0] res_reg;
    logic [25:0] den_reg;
    logic        done_reg;

    logic [50:0] trial;
    logic [50:0] rem_sh;
    logic        fits;

    // one quotient or root bit per cycle
    always_comb
    begin
        if (is_div_reg)
        begin
            rem_sh = {rem_reg[49:0], num_reg[49]};
            trial  = {25'd0, den_reg};
        end
        else
        begin
            rem_sh = {rem_reg[48:0], num_reg[49:48]};
            trial  = {res_reg[48:0], 2'b01};
        end
        fits = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg   <= 1'b1;
                is_div_reg <= req.is_div;
                num_reg    <= req.num;
                den_reg    <= req.den;
                rem_reg    <= '0;
                res_reg    <= '0;
                cnt_reg    <= req.is_div ? 6'd50 : 6'd25;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? rem_sh - trial : rem_sh;
                res_reg <= {res_reg[48:0], fits};
                num_reg <= is_div_reg ? {num_reg[48:0], 1'b0} : {num_reg[47:0], 2'b00};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = res_reg;

endmodule

// ----- rtl/queued_linear_move_interpolator.sv -----
//------------------------------------------------------------------------------
// queued_linear_move_interpolator
// 3-axis position keeper with a target queue, constant-speed moves and jog
//------------------------------------------------------------------------------
// One transaction is handled at a time. A target, a jog, a move tick on an
// empty queue and the unused kind go from the read state to the output state.
// A move tick that snaps to the head target goes through a read, three square
// states, the distance test and the output state. A move tick that steps along
// the line goes through a read, three square states, one distance test, a
// square root and three divides on the one shared bit-serial root/divide unit,
// one apply state and the output state. in_stall stays high from acceptance
// until the result is taken, and the next transaction can be accepted in the
// cycle after that. The target queue is a memory with a registered read; its
// entries are undefined until written.
module queued_linear_move_interpolator
#(
    parameter int QUEUE_DEPTH = qlmi_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  qlmi_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output qlmi_pkg::out_item_t  out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_SQ    = 4'd2;
    localparam logic [3:0] S_SUM   = 4'd3;
    localparam logic [3:0] S_ROOT  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_APPLY = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_SQ2   = 4'd8;
    localparam logic [3:0] S_SQ3   = 4'd9;

    // configuration registers
    logic signed [23:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg, min_z_reg, max_z_reg;
    logic [15:0]        move_step_reg, jog_step_reg;

    logic signed [23:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [QA_W-1:0]    head_reg;
    logic [QC_W-1:0]    count_reg;
    logic [3:0]         state_reg;
    logic [1:0]         status_reg;
    qlmi_pkg::in_item_t item_reg;

    logic [71:0]        queue_mem [QUEUE_DEPTH];
    logic [71:0]        rd_reg;
    logic               wr_en;
    logic [QA_W-1:0]    wr_addr;
    logic [71:0]        wr_data;

    // move datapath registers
    logic signed [24:0] d_reg [3];
    logic [49:0]        sq_reg;
    logic [49:0]        sum_reg;
    logic [24:0]        dist_reg;
    logic [1:0]         axis_reg;
    logic signed [24:0] step_reg [3];

    qlmi_pkg::alu_req_t alu_req;
    qlmi_pkg::alu_req_t div_req;
    qlmi_pkg::alu_rsp_t alu_rsp;

    qlmi_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (alu_rsp)
    );

    // apb: writes in the access phase, reads return the register
    logic cfg_we;
    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[4:2])
            qlmi_pkg::REG_MIN_X:     prdata = {{8{min_x_reg[23]}}, min_x_reg};
            qlmi_pkg::REG_MAX_X:     prdata = {{8{max_x_reg[23]}}, max_x_reg};
            qlmi_pkg::REG_MIN_Y:     prdata = {{8{min_y_reg[23]}}, min_y_reg};
            qlmi_pkg::REG_MAX_Y:     prdata = {{8{max_y_reg[23]}}, max_y_reg};
            qlmi_pkg::REG_MIN_Z:     prdata = {{8{min_z_reg[23]}}, min_z_reg};
            qlmi_pkg::REG_MAX_Z:     prdata = {{8{max_z_reg[23]}}, max_z_reg};
            qlmi_pkg::REG_MOVE_STEP: prdata = {16'd0, move_step_reg};
            default:                 prdata = {16'd0, jog_step_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg     <= -24'sd327680;
            max_x_reg     <= 24'sd327680;
            min_y_reg     <= 24'sd0;
            max_y_reg     <= 24'sd131072;
            min_z_reg     <= -24'sd327680;
            max_z_reg     <= 24'sd327680;
            move_step_reg <= 16'd655;
            jog_step_reg  <= 16'd655;
        end
        else if (cfg_we && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[4:2])
                qlmi_pkg::REG_MIN_X:     min_x_reg <= pwdata[23:0];
                qlmi_pkg::REG_MAX_X:     max_x_reg <= pwdata[23:0];
                qlmi_pkg::REG_MIN_Y:     min_y_reg <= pwdata[23:0];
                qlmi_pkg::REG_MAX_Y:     max_y_reg <= pwdata[23:0];
                qlmi_pkg::REG_MIN_Z:     min_z_reg <= pwdata[23:0];
                qlmi_pkg::REG_MAX_Z:     max_z_reg <= pwdata[23:0];
                qlmi_pkg::REG_MOVE_STEP: move_step_reg <= pwdata[15:0];
                default:                 jog_step_reg <= pwdata[15:0];
            endcase
        end
    end

    // clamp: min wins when bounds are inverted
    function automatic logic signed [23:0] clampv(logic signed [23:0] v,
                                                  logic signed [23:0] lo,
                                                  logic signed [23:0] hi);
        logic signed [23:0] t;
        t = (v < hi) ? v : hi;
        return (t > lo) ? t : lo;
    endfunction

    function automatic logic signed [23:0] jog_axis(logic signed [23:0] p,
                                                    logic signed [23:0] lo,
                                                    logic signed [23:0] hi,
                                                    logic [15:0] s,
                                                    logic k_first, logic first_minus,
                                                    logic k_second, logic second_minus);
        logic signed [25:0] pm;
        logic signed [25:0] pp;
        logic signed [25:0] r;
        pm = 26'(p) - 26'(signed'({1'b0, s}));
        pp = 26'(p) + 26'(signed'({1'b0, s}));
        r  = 26'(p);
        if (k_first && (first_minus ? pm >= 26'(lo) : pp <= 26'(hi)))
            r = first_minus ? pm : pp;
        if (k_second && (second_minus ? pm >= 26'(lo) : pp <= 26'(hi)))
            r = second_minus ? pm : pp;
        return r[23:0];
    endfunction

    // queue memory
    assign wr_addr = QA_W'((QC_W+QA_W+1)'(head_reg) + (QC_W+QA_W+1)'(count_reg)
                     - ((QC_W+QA_W+1)'(head_reg) + (QC_W+QA_W+1)'(count_reg)
                        >= (QC_W+QA_W+1)'(QUEUE_DEPTH) ? (QC_W+QA_W+1)'(QUEUE_DEPTH)
                                                      : '0));
    always_comb
    begin
        wr_data = {clampv(item_reg.axis_mask[0] ? item_reg.target_x : pos_x_reg,
                          min_x_reg, max_x_reg),
                   clampv(item_reg.axis_mask[1] ? item_reg.target_y : pos_y_reg,
                          min_y_reg, max_y_reg),
                   clampv(item_reg.axis_mask[2] ? item_reg.target_z : pos_z_reg,
                          min_z_reg, max_z_reg)};
    end
    assign wr_en = (state_reg == S_READ) && (item_reg.kind == qlmi_pkg::KIND_TARGET)
                   && (count_reg < QC_W'(QUEUE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            queue_mem[wr_addr] <= wr_data;
        rd_reg <= queue_mem[head_reg];
    end

    // shared unit requests
    logic [1:0]         sq_sel;
    logic signed [49:0] sq_ext;
    logic [49:0]        sq_prod;
    logic [24:0]        mag;
    logic [31:0]        step_pr;
    always_comb
    begin
        sq_sel  = (state_reg == S_SQ) ? 2'd0 : (state_reg == S_SQ2) ? 2'd1 : 2'd2;
        mag     = d_reg[axis_reg][24] ? 25'(-d_reg[axis_reg]) : 25'(d_reg[axis_reg]);
        step_pr = 32'(move_step_reg) * 32'(move_step_reg);
        sq_ext  = 50'(d_reg[sq_sel]);
        sq_prod = $unsigned(sq_ext * sq_ext);
        alu_req = '0;
        if (state_reg == S_SUM && sum_reg > 50'(step_pr))
        begin
            alu_req.start = 1'b1;
            alu_req.num   = sum_reg;
        end
    end

    // divide numerator 2*|d|*step + dist, denominator 2*dist
    logic [49:0] div_num;
    assign div_num = 50'(({25'd0, mag} * {34'd0, move_step_reg}) << 1) + 50'(dist_reg);

    // the unit sees either the root request or a divide
    logic div_start_reg;
    always_comb
    begin
        div_req        = alu_req;
        if (div_start_reg)
        begin
            div_req.start  = 1'b1;
            div_req.is_div = 1'b1;
            div_req.num    = div_num;
            div_req.den    = {dist_reg, 1'b0};
        end
    end

    logic        accept;
    logic signed [25:0] new_p [3];
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            new_p[i] = 26'(step_reg[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            status_reg    <= qlmi_pkg::ST_OK;
            div_start_reg <= 1'b0;
            axis_reg      <= '0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg   <= in_data;
                        status_reg <= qlmi_pkg::ST_OK;
                        state_reg  <= S_READ;
                    end
                end
                S_READ:
                begin
                    // rd_reg for head is valid this cycle start (head stable)
                    state_reg <= S_OUT;
                    case (item_reg.kind)
                        qlmi_pkg::KIND_TARGET:
                        begin
                            if (count_reg >= QC_W'(QUEUE_DEPTH))
                                status_reg <= qlmi_pkg::ST_DROPPED;
                            else
                                count_reg <= count_reg + QC_W'(1);
                        end
                        qlmi_pkg::KIND_MOVE:
                        begin
                            if (count_reg != '0)
                            begin
                                d_reg[0]  <= 25'(signed'(rd_reg[71:48])) - 25'(pos_x_reg);
                                d_reg[1]  <= 25'(signed'(rd_reg[47:24])) - 25'(pos_y_reg);
                                d_reg[2]  <= 25'(signed'(rd_reg[23:0]))  - 25'(pos_z_reg);
                                sum_reg   <= '0;
                                state_reg <= S_SQ;
                            end
                        end
                        qlmi_pkg::KIND_JOG:
                        begin
                            pos_z_reg <= jog_axis(pos_z_reg, min_z_reg, max_z_reg, jog_step_reg,
                                                  item_reg.jog_keys[0], 1'b1,
                                                  item_reg.jog_keys[1], 1'b0);
                            pos_x_reg <= jog_axis(pos_x_reg, min_x_reg, max_x_reg, jog_step_reg,
                                                  item_reg.jog_keys[2], 1'b1,
                                                  item_reg.jog_keys[3], 1'b0);
                            pos_y_reg <= jog_axis(pos_y_reg, min_y_reg, max_y_reg, jog_step_reg,
                                                  item_reg.jog_keys[4], 1'b0,
                                                  item_reg.jog_keys[5], 1'b1);
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_SQ:
                begin
                    sq_reg    <= sq_prod;
                    state_reg <= S_SQ2;
                end
                S_SQ2:
                begin
                    sum_reg   <= sum_reg + sq_reg;
                    sq_reg    <= sq_prod;
                    state_reg <= S_SQ3;
                end
                S_SQ3:
                begin
                    sum_reg   <= sum_reg + sq_reg + sq_prod;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (sum_reg > 50'(step_pr))
                        state_reg <= S_ROOT;
                    else
                    begin
                        pos_x_reg  <= rd_reg[71:48];
                        pos_y_reg  <= rd_reg[47:24];
                        pos_z_reg  <= rd_reg[23:0];
                        head_reg   <= (head_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : head_reg + QA_W'(1);
                        count_reg  <= count_reg - QC_W'(1);
                        status_reg <= qlmi_pkg::ST_REACHED;
                        state_reg  <= S_OUT;
                    end
                end
                S_ROOT:
                begin
                    if (alu_rsp.done)
                    begin
                        dist_reg      <= (alu_rsp.quo[24:0] == '0) ? 25'd1 : alu_rsp.quo[24:0];
                        axis_reg      <= 2'd0;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (alu_rsp.done)
                    begin
                        step_reg[axis_reg] <= d_reg[axis_reg][24] ? -25'(alu_rsp.quo[24:0])
                                                                  : 25'(alu_rsp.quo[24:0]);
                        if (axis_reg == 2'd2)
                            state_reg <= S_APPLY;
                        else
                        begin
                            axis_reg      <= axis_reg + 2'd1;
                            div_start_reg <= 1'b1;
                        end
                    end
                end
                S_APPLY:
                begin
                    pos_x_reg <= 24'(26'(pos_x_reg) + new_p[0]);
                    pos_y_reg <= 24'(26'(pos_y_reg) + new_p[1]);
                    pos_z_reg <= 24'(26'(pos_z_reg) + new_p[2]);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // result transaction
    assign out_valid = (state_reg == S_OUT);
    always_comb
    begin
        out_data.pos_x   = pos_x_reg;
        out_data.pos_y   = pos_y_reg;
        out_data.pos_z   = pos_z_reg;
        out_data.pending = 5'(count_reg);
        out_data.status  = status_reg;
    end

endmodule
